// ----- hdl/xpg_pkg.sv -----
package xpg_pkg;

  // Fixed field widths.
  localparam int CountWidth = 15;
  localparam int PosWidth   = 14;
  localparam int HalfWidth  = 14;
  localparam int RingDepth  = 64;
  localparam int RingAw     = 6;

  // Default scratchpad depth and the reset value of the length register.
  localparam int DefPadWords = 16384;
  localparam logic [CountWidth-1:0] PadLengthReset = 15'd16384;

  // Output multiplier of the generator, split into 32-bit halves.
  localparam logic [63:0] GenMult   = 64'd8372773778140471301;
  localparam logic [31:0] GenMultLo = GenMult[31:0];
  localparam logic [31:0] GenMultHi = GenMult[63:32];

  // Command codes on the input.
  localparam logic [1:0] CmdLoad  = 2'd0;
  localparam logic [1:0] CmdBegin = 2'd1;
  localparam logic [1:0] CmdGen   = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_BEGIN,
    OP_GEN
  } op_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [5:0]  word_slot;
    logic [63:0] seed_value;
    logic [5:0]  ring_start;
  } cmd_t;

  typedef struct packed {
    logic [PosWidth-1:0] pad_position;
    logic [63:0]         pad_value;
    logic                last_word;
    logic                status;
  } result_t;

  // One classified transaction waiting in the queue.
  typedef struct packed {
    op_e         op;
    logic [5:0]  word_slot;
    logic [63:0] seed_value;
    logic [5:0]  ring_start;
  } entry_t;

  // Handshake between the queue and the execution unit.
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } queue_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RDA,
    ST_RDB,
    ST_MIX,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_DIV,
    ST_PRD,
    ST_PXOR,
    ST_WRITE
  } state_e;

endpackage

// ----- hdl/xpg_ram.sv -----
module xpg_ram #(
  parameter int Width = 64,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/xpg_front.sv -----
module xpg_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  xpg_pkg::cmd_t     cmd_i,
  output logic              full_o,
  input  logic              pop_i,
  output xpg_pkg::queue_out_t q_o
);
  import xpg_pkg::*;

  entry_t     slot_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       keep;
  entry_t     ent;

  // Classify the command; the unused code is dropped here.
  always_comb begin
    keep           = 1'b1;
    ent.op         = OP_LOAD;
    ent.word_slot  = cmd_i.word_slot;
    ent.seed_value = cmd_i.seed_value;
    ent.ring_start = cmd_i.ring_start;
    unique case (cmd_i.command)
      CmdLoad:  ent.op = OP_LOAD;
      CmdBegin: ent.op = OP_BEGIN;
      CmdGen:   ent.op = OP_GEN;
      default:  keep = 1'b0;
    endcase
  end

  // Two-entry queue pointers and fill count.
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i && keep) begin
      wptr_d = ~wptr_q;
    end
    if (pop_i) begin
      rptr_d = ~rptr_q;
    end
    cnt_d = cnt_q + 2'(push_i && keep) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push_i && keep) begin
      slot_q[wptr_q] <= ent;
    end
  end

  assign full_o     = (cnt_q == 2'd2);
  assign q_o.valid  = (cnt_q != 2'd0);
  assign q_o.entry  = slot_q[rptr_q];

endmodule

// ----- hdl/xpg_back.sv -----
module xpg_back #(
  parameter int PadWords = xpg_pkg::DefPadWords
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  xpg_pkg::queue_out_t                 q_i,
  output logic                                pop_o,
  input  logic [xpg_pkg::CountWidth-1:0]      pad_length_i,
  output logic                                res_valid_o,
  output xpg_pkg::result_t                    res_o
);
  import xpg_pkg::*;

  localparam int Aw = $clog2(PadWords);

  state_e state_q, state_d;

  entry_t                ent_q;
  logic [CountWidth-1:0] count_q;
  logic [CountWidth-1:0] pos_q;
  logic [RingAw-1:0]     rp_q;
  logic [RingDepth-1:0]  vld_q;
  logic                  rvld_q;
  logic [63:0]           a_q, x_q, v_q, r_q, ll_q, p_q;
  logic [31:0]           cr_q;
  logic                  second_q;
  logic [CountWidth-1:0] rem_q;
  logic [5:0]            dcnt_q;

  logic                  ring_we;
  logic [RingAw-1:0]     ring_waddr, ring_raddr;
  logic [63:0]           ring_wdata, ring_rdata, ring_word;
  logic                  pad_we;
  logic [Aw-1:0]         pad_waddr, pad_raddr;
  logic [63:0]           pad_rdata;

  logic [31:0]           mul_a, mul_b;
  logic [63:0]           mul_res;
  logic [31:0]           pl_w, len_w, pos_w, idx_w;
  logic [CountWidth-1:0] len;
  logic                  full;
  logic [HalfWidth-1:0]  half;
  logic [CountWidth-1:0] rem_sh, rem_nx;
  logic [63:0]           a_mix, b_mix;
  logic                  draw_again;

  // Effective pad length, saturated to the supported range.
  always_comb begin
    pl_w = 32'(pad_length_i);
    if (pl_w < 32'd2) begin
      len_w = 32'd2;
    end else if (pl_w > 32'(PadWords)) begin
      len_w = 32'(PadWords);
    end else begin
      len_w = pl_w;
    end
    len  = len_w[CountWidth-1:0];
    full = (count_q >= len);
  end

  // Generator mixing of the two ring words.
  assign ring_word = rvld_q ? ring_rdata : 64'd0;
  always_comb begin
    a_mix = a_q ^ (a_q >> 49);
    b_mix = ring_word ^ (ring_word << 25);
    b_mix = b_mix ^ (b_mix >> 3);
  end

  // Shared 32x32 multiplier for the three partial products.
  always_comb begin
    mul_a = x_q[31:0];
    mul_b = GenMultLo;
    case (state_q)
      ST_MUL1: mul_b = GenMultHi;
      ST_MUL2: mul_a = x_q[63:32];
      default: ;
    endcase
  end
  assign mul_res    = ll_q + {cr_q + p_q[31:0], 32'd0};
  assign draw_again = (pos_q >= 15'd2) && (mul_res[8:0] == 9'd0);

  // One restoring division step on the second draw.
  assign half   = pos_q[CountWidth-1:1];
  assign rem_sh = {rem_q[CountWidth-2:0], r_q[63]};
  assign rem_nx = (rem_sh >= 15'(half)) ? rem_sh - 15'(half) : rem_sh;

  assign pos_w = 32'(pos_q);
  assign idx_w = 32'(rem_q + 15'(half));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (q_i.valid) state_d = ST_EXEC;
      ST_EXEC: begin
        if (ent_q.op == OP_GEN && !full) begin
          state_d = ST_RDA;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_RDA:   state_d = ST_RDB;
      ST_RDB:   state_d = ST_MIX;
      ST_MIX:   state_d = ST_MUL0;
      ST_MUL0:  state_d = ST_MUL1;
      ST_MUL1:  state_d = ST_MUL2;
      ST_MUL2:  state_d = ST_MUL3;
      ST_MUL3: begin
        if (second_q) begin
          state_d = ST_DIV;
        end else if (draw_again) begin
          state_d = ST_RDA;
        end else begin
          state_d = ST_WRITE;
        end
      end
      ST_DIV:   if (dcnt_q == 6'd63) state_d = ST_PRD;
      ST_PRD:   state_d = ST_PXOR;
      ST_PXOR:  state_d = ST_WRITE;
      ST_WRITE: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Memory controls, queue pop and result strobe.
  always_comb begin
    pop_o       = 1'b0;
    ring_we     = 1'b0;
    ring_waddr  = ent_q.word_slot;
    ring_wdata  = ent_q.seed_value;
    ring_raddr  = rp_q;
    pad_we      = 1'b0;
    pad_waddr   = pos_w[Aw-1:0];
    pad_raddr   = idx_w[Aw-1:0];
    res_valid_o = 1'b0;
    res_o       = '0;
    unique case (state_q)
      ST_IDLE: pop_o = q_i.valid;
      ST_EXEC: begin
        ring_we = (ent_q.op == OP_LOAD);
        if (ent_q.op == OP_GEN && full) begin
          res_valid_o  = 1'b1;
          res_o.status = 1'b1;
        end
      end
      ST_RDB: ring_raddr = rp_q + 6'd1;
      ST_MIX: begin
        ring_we    = 1'b1;
        ring_waddr = rp_q;
        ring_wdata = a_mix ^ b_mix;
      end
      ST_WRITE: begin
        pad_we             = 1'b1;
        res_valid_o        = 1'b1;
        res_o.pad_position = pos_q[PosWidth-1:0];
        res_o.pad_value    = v_q;
        res_o.last_word    = (pos_q == len - 15'd1);
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      rp_q    <= '0;
      vld_q   <= '0;
    end else begin
      state_q <= state_d;
      if (ring_we) begin
        vld_q[ring_waddr] <= 1'b1;
      end
      if (state_q == ST_EXEC && ent_q.op == OP_BEGIN) begin
        rp_q    <= ent_q.ring_start;
        count_q <= '0;
      end
      if (state_q == ST_RDB) begin
        rp_q <= rp_q + 6'd1;
      end
      if (state_q == ST_WRITE) begin
        count_q <= pos_q + 15'd1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    rvld_q <= vld_q[ring_raddr];
    p_q    <= mul_a * mul_b;
    case (state_q)
      ST_IDLE: ent_q <= q_i.entry;
      ST_EXEC: begin
        pos_q    <= count_q;
        second_q <= 1'b0;
      end
      ST_RDB:  a_q <= ring_word;
      ST_MIX:  x_q <= a_mix ^ b_mix;
      ST_MUL1: ll_q <= p_q;
      ST_MUL2: cr_q <= p_q[31:0];
      ST_MUL3: begin
        if (second_q) begin
          r_q <= mul_res;
        end else begin
          v_q <= mul_res;
        end
        second_q <= 1'b1;
        rem_q    <= '0;
        dcnt_q   <= '0;
      end
      ST_DIV: begin
        rem_q  <= rem_nx;
        r_q    <= {r_q[62:0], 1'b0};
        dcnt_q <= dcnt_q + 6'd1;
      end
      ST_PXOR: v_q <= v_q ^ pad_rdata;
      default: ;
    endcase
  end

  xpg_ram #(.Width(64), .Depth(RingDepth)) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_waddr),
    .wdata_i (ring_wdata),
    .raddr_i (ring_raddr),
    .rdata_o (ring_rdata)
  );

  xpg_ram #(.Width(64), .Depth(PadWords)) u_pad (
    .clk_i   (clk_i),
    .we_i    (pad_we),
    .waddr_i (pad_waddr),
    .wdata_i (v_q),
    .raddr_i (pad_raddr),
    .rdata_o (pad_rdata)
  );

endmodule

// ----- hdl/xorshift_pad_generator_top.sv -----
// Generate transaction: the result follows one generator step, or, when the word draws a
// second number, a second generator step plus a bit-serial modulo and a pad XOR.
// Load and begin finish on execution; one item executes at a time, two more may queue.
// Pad-full result: status set, no word. The receiver cannot stall results.
// Reset (rst_ni low, asynchronous) zeroes the generator ring through valid bits, the
// ring position and pad count, and sets pad_length to 16384; pad contents stay undefined.
module xorshift_pad_generator_top #(
  parameter int PAD_WORDS = xpg_pkg::DefPadWords
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  xpg_pkg::cmd_t                  cmd_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [xpg_pkg::CountWidth-1:0] cfg_data_i,
  output logic                           result_valid_o,
  output xpg_pkg::result_t               result_o
);
  import xpg_pkg::*;

  logic [CountWidth-1:0] pad_length_q;
  queue_out_t            q;
  logic                  pop;

  // Length register.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad_length_q <= PadLengthReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      pad_length_q <= cfg_data_i;
    end
  end

  xpg_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (start && !busy),
    .cmd_i  (cmd_i),
    .full_o (busy),
    .pop_i  (pop),
    .q_o    (q)
  );

  xpg_back #(.PadWords(PAD_WORDS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_i          (q),
    .pop_o        (pop),
    .pad_length_i (pad_length_q),
    .res_valid_o  (result_valid_o),
    .res_o        (result_o)
  );

  // A full status carries no word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.status |-> result_o.pad_value == 64'd0 && !result_o.last_word)
    else $error("full status with payload");

  // Results never come in consecutive cycles.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("back-to-back results");

  // The queue is never popped when empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q.valid)
    else $error("pop from empty queue");

endmodule
